// ===== rtl/assert_macros.svh =====
// Assertion macros included by the queue core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== rtl/borq_pkg.sv =====
// Types and constants of the burst ordered ready queue.
package borq_pkg;

   // Default number of queue slots.
   localparam int DEPTH_DEFAULT = 16;

   // Widths of the result fields.
   localparam int COUNT_W = 5;
   localparam int LOAD_W  = 20;
   localparam int RSP_W   = 80;

   // Operation carried by each request word.
   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_SORT   = 2'd3
   } op_type;

   // Status returned with each response word.
   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // One queue entry; pid sits in the lowest bits.
   typedef struct packed {
      logic [15:0] remain;
      logic [15:0] burst;
      logic [15:0] pid;
   } entry_type;

endpackage

// ===== rtl/borq_slot_ram.sv =====
// Slot memory of the queue: one write port, one registered read port.
module borq_slot_ram
   import borq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data
);

   entry_type mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/burst_ordered_ready_queue_core.sv =====
// Top level of the burst ordered ready queue.
//
// A bounded queue of process entries (pid, burst length, remaining time).
// Each request word carries an operation in req_tuser: append at the tail,
// insert in ascending burst order behind equal keys, remove the head, or
// stably sort all entries by pid. Every request gives exactly one response
// word with the removed entry (zeros if none), a status in rsp_tuser, the
// entry count and the sum of remaining times.
// Entries live in a circular slot memory with a registered read; all work
// is done as reads, compares and write-backs through that single port pair.
// Append and a failed operation go straight from acceptance to the response;
// remove first reads the head. Insert scans up to the insert point one slot
// a cycle, then shifts the tail one slot a cycle and writes the new entry
// into the gap, or writes it at the tail if no larger burst is found. Sort is
// an insertion sort by pid, each key compared and moved one entry at a time.
// One request is worked on at a time; a new request is taken while an
// earlier response still waits in the output register.
// Reset empties the queue at once; slot contents are not cleared.
// When the receiver stalls, the finished response is held and the block
// waits before delivering the next one.
module burst_ordered_ready_queue_core
   import borq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // [15:0] pid, [31:16] burst, [47:32] remain
   input  logic [47:0]      req_tdata,
   // [1:0] op
   input  logic [1:0]       req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // [15:0] out_pid, [31:16] out_burst, [47:32] out_remaining,
   // [52:48] entry_count, [72:53] remain_sum, [79:73] zero
   output logic [RSP_W-1:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]       rsp_tuser
);

`include "assert_macros.svh"

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_HEAD   = 9'b000000010,
      S_SCAN   = 9'b000000100,
      S_SHIFT  = 9'b000001000,
      S_PLACE  = 9'b000010000,
      S_KEY    = 9'b000100000,
      S_CMP    = 9'b001000000,
      S_PUTKEY = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        hd_ff, hd_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [LOAD_W-1:0]       load_ff, load_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        jdx_ff, jdx_in;
   entry_type               new_ff, new_in;
   entry_type               key_ff, key_in;
   entry_type               rem_ff, rem_in;
   status_type              status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]        rsp_data_ff, rsp_data_in;
   status_type              rsp_status_ff, rsp_status_in;

   logic                    ram_rd_en;
   logic [CNT_W-1:0]        ram_rd_lidx;
   logic [IDX_W-1:0]        ram_rd_phys;
   entry_type               ram_rd_data;
   logic                    ram_wr_en;
   logic [CNT_W-1:0]        ram_wr_lidx;
   logic [IDX_W-1:0]        ram_wr_phys;
   entry_type               ram_wr_data;

   entry_type               req_entry;
   op_type                  req_op;
   logic                    req_fire;
   logic                    out_free;
   logic                    q_full;
   logic [31:0]             cnt_wide;

   // Logical slot (0 is the head) to physical address in the circular memory.
   function automatic logic [IDX_W-1:0] to_phys(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] lidx);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(lidx);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   assign req_entry  = entry_type'(req_tdata);
   assign req_op     = op_type'(req_tuser);
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign q_full     = (cnt_ff == CNT_W'(DEPTH));

   assign ram_rd_phys = to_phys(hd_ff, ram_rd_lidx);
   assign ram_wr_phys = to_phys(hd_ff, ram_wr_lidx);

   borq_slot_ram #(
      .DEPTH(DEPTH),
      .IDX_W(IDX_W)
   ) u_slot_ram (
      .clock  (clock),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_phys),
      .rd_data(ram_rd_data),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_phys),
      .wr_data(ram_wr_data)
   );

   // Sequencer: decodes a request and walks the slot memory.
   always_comb begin
      state_in      = state_ff;
      hd_in         = hd_ff;
      cnt_in        = cnt_ff;
      load_in       = load_ff;
      idx_in        = idx_ff;
      jdx_in        = jdx_ff;
      new_in        = new_ff;
      key_in        = key_ff;
      rem_in        = rem_ff;
      status_in     = status_ff;
      ram_rd_en     = 1'b0;
      ram_rd_lidx   = idx_ff;
      ram_wr_en     = 1'b0;
      ram_wr_lidx   = jdx_ff;
      ram_wr_data   = key_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               new_in    = req_entry;
               rem_in    = '0;
               status_in = ST_DONE;
               state_in  = S_DONE;
               unique case (req_op)
                  OP_APPEND, OP_INSERT: begin
                     if (q_full) begin
                        status_in = ST_FULL;
                     end else if (req_op == OP_APPEND || cnt_ff == '0) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_lidx = cnt_ff;
                        ram_wr_data = req_entry;
                        cnt_in      = cnt_ff + 1'b1;
                        load_in     = load_ff + LOAD_W'(req_entry.remain);
                     end else begin
                        idx_in      = '0;
                        ram_rd_en   = 1'b1;
                        ram_rd_lidx = '0;
                        state_in    = S_SCAN;
                     end
                  end
                  OP_REMOVE: begin
                     if (cnt_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_lidx = '0;
                        state_in    = S_HEAD;
                     end
                  end
                  OP_SORT: begin
                     if (cnt_ff >= CNT_W'(2)) begin
                        idx_in      = CNT_W'(1);
                        ram_rd_en   = 1'b1;
                        ram_rd_lidx = CNT_W'(1);
                        state_in    = S_KEY;
                     end
                  end
                  default: begin
                     status_in = ST_DONE;
                  end
               endcase
            end
         end

         // Head word has arrived: hand it out and advance the head.
         S_HEAD: begin
            rem_in   = ram_rd_data;
            hd_in    = (hd_ff == IDX_W'(DEPTH - 1)) ? '0 : hd_ff + 1'b1;
            cnt_in   = cnt_ff - 1'b1;
            load_in  = load_ff - LOAD_W'(ram_rd_data.remain);
            state_in = S_DONE;
         end

         // Look for the first entry with a larger burst length.
         S_SCAN: begin
            if (ram_rd_data.burst > new_ff.burst) begin
               jdx_in      = cnt_ff;
               ram_rd_en   = 1'b1;
               ram_rd_lidx = cnt_ff - 1'b1;
               state_in    = S_SHIFT;
            end else if (idx_ff + 1'b1 == cnt_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_lidx = cnt_ff;
               ram_wr_data = new_ff;
               cnt_in      = cnt_ff + 1'b1;
               load_in     = load_ff + LOAD_W'(new_ff.remain);
               state_in    = S_DONE;
            end else begin
               idx_in      = idx_ff + 1'b1;
               ram_rd_en   = 1'b1;
               ram_rd_lidx = idx_ff + 1'b1;
            end
         end

         // Move one entry up a slot per cycle down to the insert point.
         S_SHIFT: begin
            ram_wr_en   = 1'b1;
            ram_wr_lidx = jdx_ff;
            ram_wr_data = ram_rd_data;
            jdx_in      = jdx_ff - 1'b1;
            if (jdx_ff - 1'b1 == idx_ff) begin
               state_in = S_PLACE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_lidx = jdx_ff - CNT_W'(2);
            end
         end

         // Write the new entry into the gap.
         S_PLACE: begin
            ram_wr_en   = 1'b1;
            ram_wr_lidx = idx_ff;
            ram_wr_data = new_ff;
            cnt_in      = cnt_ff + 1'b1;
            load_in     = load_ff + LOAD_W'(new_ff.remain);
            state_in    = S_DONE;
         end

         // Sort: take slot idx as the key and fetch its left neighbor.
         S_KEY: begin
            key_in      = ram_rd_data;
            jdx_in      = idx_ff;
            ram_rd_en   = 1'b1;
            ram_rd_lidx = idx_ff - 1'b1;
            state_in    = S_CMP;
         end

         // Sort: move larger pids right, or drop the key in place.
         S_CMP: begin
            ram_wr_en   = 1'b1;
            ram_wr_lidx = jdx_ff;
            if (ram_rd_data.pid > key_ff.pid) begin
               ram_wr_data = ram_rd_data;
               jdx_in      = jdx_ff - 1'b1;
               if (jdx_ff == CNT_W'(1)) begin
                  state_in = S_PUTKEY;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_lidx = jdx_ff - CNT_W'(2);
               end
            end else begin
               ram_wr_data = key_ff;
               if (idx_ff + 1'b1 == cnt_ff) begin
                  state_in = S_DONE;
               end else begin
                  idx_in      = idx_ff + 1'b1;
                  ram_rd_en   = 1'b1;
                  ram_rd_lidx = idx_ff + 1'b1;
                  state_in    = S_KEY;
               end
            end
         end

         // Sort: the key goes to the head slot.
         S_PUTKEY: begin
            ram_wr_en   = 1'b1;
            ram_wr_lidx = '0;
            ram_wr_data = key_ff;
            if (idx_ff + 1'b1 == cnt_ff) begin
               state_in = S_DONE;
            end else begin
               idx_in      = idx_ff + 1'b1;
               ram_rd_en   = 1'b1;
               ram_rd_lidx = idx_ff + 1'b1;
               state_in    = S_KEY;
            end
         end

         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: loaded from the finished operation, held while stalled.
   assign cnt_wide = 32'(cnt_ff);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      if (state_ff == S_DONE && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = {7'd0, load_ff, cnt_wide[COUNT_W-1:0], rem_ff.remain,
                          rem_ff.burst, rem_ff.pid};
         rsp_status_in = status_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hd_ff        <= '0;
         cnt_ff       <= '0;
         load_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hd_ff        <= hd_in;
         cnt_ff       <= cnt_in;
         load_ff      <= load_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      jdx_ff        <= jdx_in;
      new_ff        <= new_in;
      key_ff        <= key_in;
      rem_ff        <= rem_in;
      status_ff     <= status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   // The count never passes the number of slots.
   `ASSERT_CLK(a_cnt_bound, cnt_ff <= CNT_W'(DEPTH), "entry count above depth")

   // An empty queue carries no load.
   `ASSERT_CLK(a_empty_load, cnt_ff == '0 |-> load_ff == '0, "load left in empty queue")

   // The sequencer never reads and writes one slot in the same cycle.
   `ASSERT_CLK(a_no_rw_clash, ram_rd_en && ram_wr_en |-> ram_rd_phys != ram_wr_phys, "slot clash")

   // A full status is only reported for a full queue.
   `ASSERT_CLK(a_full_status, state_ff == S_DONE && status_ff == ST_FULL |-> q_full, "false full")

endmodule

// ===== verif/borq_scoreboard_pkg.sv =====
// Scoreboard of the burst ordered ready queue testbench.
`timescale 1ns / 1ps

package borq_scoreboard_pkg;
   import borq_pkg::*;

   // What one response word should carry.
   typedef struct {
      entry_type          removed;
      status_type         status;
      logic [COUNT_W-1:0] count;
      logic [LOAD_W-1:0]  load;
   } result_type;

   class ready_queue_scoreboard;
      entry_type         slots[DEPTH_DEFAULT];
      int                held;
      logic [LOAD_W-1:0] load;
      result_type        awaited[$];
      int                errors;

      function new();
         held = 0;
         load = '0;
         errors = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // Print one mismatch line and count it.
      task report(string msg);
         $display("%0t ns: mismatch: %s", $time, msg);
         errors++;
      endtask

      // Apply an accepted request word to the shadow queue and queue up its response.
      function void note_request(op_type op, entry_type item);
         result_type  res;
         entry_type   moving;
         int          pos;
         int          j;
         res.removed = '0;
         res.status = ST_DONE;
         case (op)
            OP_APPEND, OP_INSERT: begin
               if (held >= DEPTH_DEFAULT) begin
                  res.status = ST_FULL;
               end else begin
                  pos = held;
                  // Sorted insert goes in front of the first entry with a larger burst.
                  if (op == OP_INSERT) begin
                     pos = 0;
                     while (pos < held && slots[pos].burst <= item.burst)
                        pos++;
                     for (int i = held; i > pos; i--)
                        slots[i] = slots[i-1];
                  end
                  slots[pos] = item;
                  held++;
                  load += item.remain;
               end
            end
            OP_REMOVE: begin
               if (held == 0) begin
                  res.status = ST_EMPTY;
               end else begin
                  res.removed = slots[0];
                  for (int i = 1; i < held; i++)
                     slots[i-1] = slots[i];
                  held--;
                  load -= res.removed.remain;
               end
            end
            default: begin
               // Stable insertion sort on pid; equal pids keep their order.
               for (int i = 1; i < held; i++) begin
                  moving = slots[i];
                  j = i;
                  while (j > 0 && slots[j-1].pid > moving.pid) begin
                     slots[j] = slots[j-1];
                     j--;
                  end
                  slots[j] = moving;
               end
            end
         endcase
         res.count = COUNT_W'(held);
         res.load = load;
         awaited.push_back(res);
      endfunction

      // Compare one accepted response word with the oldest expectation.
      task check_response(logic [RSP_W-1:0] data, logic [1:0] user);
         result_type res;
         if (awaited.size() == 0) begin
            report($sformatf("response word %h with nothing awaited", data));
            return;
         end
         res = awaited.pop_front();
         if (data[15:0] !== res.removed.pid)
            report($sformatf("out_pid %h, expected %h", data[15:0], res.removed.pid));
         if (data[31:16] !== res.removed.burst)
            report($sformatf("out_burst %h, expected %h", data[31:16],
                             res.removed.burst));
         if (data[47:32] !== res.removed.remain)
            report($sformatf("out_remaining %h, expected %h", data[47:32],
                             res.removed.remain));
         if (data[52:48] !== res.count)
            report($sformatf("entry_count %0d, expected %0d", data[52:48], res.count));
         if (data[72:53] !== res.load)
            report($sformatf("remain_sum %h, expected %h", data[72:53], res.load));
         if (data[79:73] !== '0)
            report($sformatf("padding bits %h not zero", data[79:73]));
         if (user !== res.status)
            report($sformatf("status %0d, expected %0d", user, res.status));
      endtask
   endclass

endpackage

// ===== verif/tb.sv =====
// Top testbench of the burst ordered ready queue.
`timescale 1ns / 1ps

module tb;
   import borq_pkg::*;
   import borq_scoreboard_pkg::*;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [47:0]      req_tdata;
   logic [1:0]       req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [1:0]       rsp_tuser;

   // Stimulus shaping flags.
   logic calm = 1'b0;
   logic stall_request = 1'b0;
   logic hold_rsp = 1'b0;

   ready_queue_scoreboard board = new();

   burst_ordered_ready_queue_core #(
      .DEPTH(DEPTH_DEFAULT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on the run.
   initial begin
      #5000000;
      $display("TB_ERROR");
      $finish;
   end

   // Receiver: random back-pressure, none while calm, held off during the long hold.
   always @(negedge clock) begin
      if (hold_rsp)
         rsp_tready = 1'b0;
      else
         rsp_tready = calm || ($urandom_range(99) >= 7);
   end

   // Long receiver hold, counted in its own process.
   initial begin
      wait (stall_request);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (80) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Response monitor.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_response(rsp_tdata, rsp_tuser);
   end

   // Offer one request word, with random idle cycles first; returns at a falling edge.
   task automatic send_word(input op_type op, input logic [15:0] pid,
                            input logic [15:0] burst, input logic [15:0] remaining);
      entry_type item;
      item.pid = pid;
      item.burst = burst;
      item.remain = remaining;
      while (!calm && $urandom_range(99) < 7) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tuser = op;
      req_tdata = {remaining, burst, pid};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      board.note_request(op, item);
      @(negedge clock);
   endtask

   // Stop offering until every awaited response word has come back.
   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (board.pending() != 0)
         @(negedge clock);
   endtask

   // Field values biased toward the ends of the range and toward repeats.
   function automatic logic [15:0] pick_value();
      case ($urandom_range(3))
         0: return 16'($urandom_range(7));
         1: return 16'hFFFF - 16'($urandom_range(3));
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   initial begin
      op_type op;
      int     add_pct;
      int     roll;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_APPEND;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty queue cases, equal keys, then fill with maximal times.
      send_word(OP_REMOVE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(OP_SORT, 16'h0000, 16'h0000, 16'h0000);
      send_word(OP_APPEND, 16'h8000, 16'd5, 16'hFFFF);
      send_word(OP_SORT, 16'h1234, 16'd9, 16'd9);
      send_word(OP_INSERT, 16'h0000, 16'd5, 16'hFFFF);
      send_word(OP_INSERT, 16'hFFFF, 16'h0000, 16'hFFFF);
      send_word(OP_INSERT, 16'h0003, 16'hFFFF, 16'hFFFF);
      send_word(OP_INSERT, 16'h0003, 16'd5, 16'hFFFF);
      for (int i = 0; i < 11; i++)
         send_word((i % 2) ? OP_APPEND : OP_INSERT, 16'(i % 4), 16'((i % 3) * 5),
                   16'hFFFF);
      send_word(OP_APPEND, 16'h5555, 16'h0001, 16'h0001);
      send_word(OP_INSERT, 16'hAAAA, 16'h0000, 16'h0002);
      send_word(OP_SORT, 16'h0000, 16'h0000, 16'h0000);
      send_word(OP_REMOVE, 16'h0000, 16'h0000, 16'h0000);
      wait_drained();

      // Random: segments that lean toward filling or draining the queue.
      for (int seg = 0; seg < 11; seg++) begin
         case (seg % 4)
            0: add_pct = 85;
            1: add_pct = 20;
            2: add_pct = 60;
            default: add_pct = 10;
         endcase
         calm <= (seg == 6);
         if (seg == 2)
            stall_request = 1'b1;
         if (seg == 4)
            wait_drained();
         for (int n = 0; n < 50; n++) begin
            roll = $urandom_range(99);
            if (roll < 8)
               op = OP_SORT;
            else if (roll < 8 + add_pct * 92 / 100)
               op = $urandom_range(1) ? OP_INSERT : OP_APPEND;
            else
               op = OP_REMOVE;
            send_word(op, pick_value(), pick_value(), pick_value());
         end
      end

      // Let the last responses come home, then a short quiet period.
      wait_drained();
      repeat (20) @(negedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/borq_pkg.sv
rtl/borq_slot_ram.sv
rtl/burst_ordered_ready_queue_core.sv
verif/borq_scoreboard_pkg.sv
verif/tb.sv
